### rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Types and constants shared by the LRU key/value cache modules.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int Depth     = 16;
  localparam int KeyBits   = 32;
  localparam int ValueBits = 32;
  localparam int SlotBits  = $clog2(Depth);
  localparam int CntBits   = $clog2(Depth + 1);
  localparam int QDepth    = 2;

  typedef enum logic [2:0] {
    KIND_FIND    = 3'd0,
    KIND_GET     = 3'd1,
    KIND_ADD     = 3'd2,
    KIND_DEL_KEY = 3'd3,
    KIND_DEL_VAL = 3'd4,
    KIND_CLEAR   = 3'd5
  } kind_e;

  typedef struct packed {
    logic [2:0]           kind;
    logic [KeyBits-1:0]   key;
    logic [ValueBits-1:0] value_in;
    logic                 move_to_front;
  } req_t;

  typedef struct packed {
    logic                 hit;
    logic [ValueBits-1:0] value_out;
    logic [4:0]           entry_count;
    logic [4:0]           evictions;
  } rsp_t;

  // Classified command handed from the front part to the back part.
  typedef struct packed {
    logic                 do_find;
    logic                 do_get;
    logic                 do_add;
    logic                 do_del;
    logic                 by_value;
    logic                 do_clear;
    logic                 mtf;
    logic [KeyBits-1:0]   key;
    logic [ValueBits-1:0] value;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_EVICT,
    ST_DONE
  } state_e;

endpackage

### rtl/lkv_front.sv
// ----------------------------------------------------------------------------
// lkv_front
// Accepts requests, decodes the kind and queues commands for the back end.
// ----------------------------------------------------------------------------
module lkv_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  lkv_pkg::req_t in_data,
  output logic          cmd_valid,
  input  logic          cmd_take,
  output lkv_pkg::cmd_t cmd
);
  import lkv_pkg::*;

  cmd_t              q [QDepth];
  logic [$clog2(QDepth):0] fill;
  logic              wr_ptr, rd_ptr;
  cmd_t              dec;
  logic              push, pop;

  always_comb begin
    dec          = '0;
    dec.key      = in_data.key;
    dec.value    = in_data.value_in;
    dec.mtf      = in_data.move_to_front;
    unique case (in_data.kind)
      KIND_FIND:    dec.do_find = 1'b1;
      KIND_GET:     dec.do_get  = 1'b1;
      KIND_ADD:     dec.do_add  = 1'b1;
      KIND_DEL_KEY: dec.do_del  = 1'b1;
      KIND_DEL_VAL: begin
        dec.do_del   = 1'b1;
        dec.by_value = 1'b1;
      end
      KIND_CLEAR:   dec.do_clear = 1'b1;
      default:      ;
    endcase
  end

  assign in_stall  = (fill == ($clog2(QDepth)+1)'(QDepth));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (fill != '0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      fill <= fill + ($clog2(QDepth)+1)'(push) - ($clog2(QDepth)+1)'(pop);
    end
  end

endmodule

### rtl/lkv_back.sv
// ----------------------------------------------------------------------------
// lkv_back
// Entry store with parallel match, rank update, eviction and result register.
// ----------------------------------------------------------------------------
module lkv_back (
  input  logic          clk,
  input  logic          rst,
  input  logic [4:0]    limit,
  input  logic          cmd_valid,
  output logic          cmd_take,
  input  lkv_pkg::cmd_t cmd,
  output logic          out_valid,
  input  logic          out_stall,
  output lkv_pkg::rsp_t out_data
);
  import lkv_pkg::*;

  logic [KeyBits-1:0]   ekey  [Depth];
  logic [ValueBits-1:0] evalue[Depth];
  logic [Depth-1:0]     valid;
  logic [SlotBits-1:0]  rank  [Depth];
  logic [CntBits-1:0]   count;

  state_e               state, state_next;
  cmd_t                 cur;
  logic [4:0]           ev;
  logic                 found;
  logic [SlotBits-1:0]  fslot;

  logic [Depth-1:0]     match;
  logic [Depth-1:0]     onehot_min;
  logic                 any_match;
  logic [SlotBits-1:0]  best_slot;
  logic [Depth-1:0]     tail_hit;
  logic [SlotBits-1:0]  tail_slot;
  logic [SlotBits-1:0]  free_slot;
  logic                 out_free;

  assign out_free = !out_valid || !out_stall;
  assign cmd_take = (state == ST_IDLE);

  // Parallel compare; pick the lowest rank among matches.
  always_comb begin
    for (int s = 0; s < Depth; s++) begin
      match[s] = valid[s] && (cur.by_value ? (evalue[s] == cur.value)
                                            : (ekey[s] == cur.key));
      tail_hit[s] = valid[s] && (rank[s] == SlotBits'(count - 1'b1));
    end
    for (int s = 0; s < Depth; s++) begin
      onehot_min[s] = match[s];
      for (int t = 0; t < Depth; t++)
        if (match[t] && rank[t] < rank[s]) onehot_min[s] = 1'b0;
    end
    any_match = |match;
    best_slot = '0;
    tail_slot = '0;
    free_slot = '0;
    for (int s = Depth - 1; s >= 0; s--) begin
      if (onehot_min[s]) best_slot = SlotBits'(s);
      if (tail_hit[s])   tail_slot = SlotBits'(s);
      if (!valid[s])     free_slot = SlotBits'(s);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (cmd_valid) state_next = ST_MATCH;
      ST_MATCH: begin
        if (cur.do_add || ((cur.do_get) && !any_match)) state_next = ST_EVICT;
        else state_next = ST_DONE;
      end
      ST_EVICT: if (!(count >= limit && count != '0)) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      for (int s = 0; s < Depth; s++) rank[s] <= '0;
    end else begin
      if (out_valid && !out_stall && state != ST_DONE) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (cmd_valid) begin
          cur   <= cmd;
          ev    <= '0;
          found <= 1'b0;
          fslot <= '0;
        end
        ST_MATCH: begin
          found <= any_match;
          fslot <= best_slot;
          if (cur.do_clear) begin
            valid <= '0;
            count <= '0;
            for (int s = 0; s < Depth; s++) rank[s] <= '0;
          end else if (any_match && (cur.do_find || cur.do_get) && cur.mtf) begin
            for (int s = 0; s < Depth; s++)
              if (valid[s] && rank[s] < rank[best_slot]) rank[s] <= rank[s] + 1'b1;
            rank[best_slot] <= '0;
          end else if (any_match && cur.do_del) begin
            valid[best_slot] <= 1'b0;
            for (int s = 0; s < Depth; s++)
              if (valid[s] && rank[s] > rank[best_slot]) rank[s] <= rank[s] - 1'b1;
            count <= count - 1'b1;
          end
        end
        ST_EVICT: begin
          if (count >= limit && count != '0) begin
            // Drop the least recent entry; it holds the highest rank.
            valid[tail_slot] <= 1'b0;
            count <= count - 1'b1;
            ev    <= ev + 1'b1;
          end else begin
            for (int s = 0; s < Depth; s++)
              if (valid[s]) rank[s] <= rank[s] + 1'b1;
            valid[free_slot]  <= 1'b1;
            rank[free_slot]   <= '0;
            ekey[free_slot]   <= cur.key;
            evalue[free_slot] <= cur.value;
            count <= count + 1'b1;
          end
        end
        ST_DONE: if (out_free) begin
          out_valid             <= 1'b1;
          out_data.entry_count  <= 5'(count);
          out_data.evictions    <= ev;
          if (cur.do_add) begin
            out_data.hit       <= 1'b0;
            out_data.value_out <= cur.value;
          end else if (cur.do_get && !found) begin
            out_data.hit       <= 1'b1;
            out_data.value_out <= cur.value;
          end else if (found && (cur.do_find || cur.do_get || cur.do_del)) begin
            out_data.hit       <= 1'b1;
            out_data.value_out <= evalue[fslot];
          end else begin
            out_data.hit       <= 1'b0;
            out_data.value_out <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value store in recency order with LRU eviction.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_stall and are decoded into a two-entry
// command queue, so the input keeps accepting while the engine works.
// The engine compares all 16 entries at once, updates ranks, evicts and
// writes the result into an output register shown on out_valid/out_stall.
// One request is in the engine at a time; the engine takes the next
// queued command only after its result register is written. Each request
// steps through take, match and result; an insert (add, or get on a miss)
// also passes an evict step between match and result, which repeats once
// per evicted entry.
// A stalled result holds in its register; the engine waits in its last
// step and the queue fills, then in_stall rises.
// Reset empties the store, the queue and the output; capacity returns
// to 16. A capacity write of zero is ignored; values above 16 act as 16.
// Write capacity only while no request is outstanding.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  lkv_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output lkv_pkg::rsp_t out_data,
  input  logic          cfg_we,
  input  logic [4:0]    cfg_data
);
  import lkv_pkg::*;

  logic [4:0] max_entries;
  logic [4:0] limit;
  logic       cmd_valid, cmd_take;
  cmd_t       cmd;

  always_ff @(posedge clk) begin
    if (rst) max_entries <= 5'd16;
    else if (cfg_we && cfg_data != '0) max_entries <= cfg_data;
  end

  assign limit = (max_entries > 5'(Depth)) ? 5'(Depth) : max_entries;

  lkv_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .cmd_valid, .cmd_take, .cmd
  );

  lkv_back u_back (
    .clk, .rst, .limit, .cmd_valid, .cmd_take, .cmd,
    .out_valid, .out_stall, .out_data
  );

endmodule

### rtl/lkv_checker.sv
// ----------------------------------------------------------------------------
// lkv_checker
// Port-level checks for the LRU key/value cache.
// ----------------------------------------------------------------------------
module lkv_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_stall,
  input lkv_pkg::rsp_t out_data
);
  import lkv_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.entry_count <= 5'(Depth))
    else $error("entry count out of range");

  a_ev_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.evictions <= 5'(Depth))
    else $error("eviction count out of range");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk, .rst, .out_valid, .out_stall, .out_data
);

### verif/lru_cache_checker.sv
// ----------------------------------------------------------------------------
// lru_cache_checker
// Watches both channels and the capacity port of the LRU key/value cache,
// keeps its own recency-ordered store, and compares every result item
// field by field against the predicted one.
// ----------------------------------------------------------------------------
module lru_cache_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_stall,
  input  lkv_pkg::req_t in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  lkv_pkg::rsp_t out_data,
  input  logic          cfg_we,
  input  logic [4:0]    cfg_data,
  output int            fail_count,
  output int            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lkv_pkg::*;

  // Entry 0 is the most recent.
  typedef struct {
    logic [KeyBits-1:0]   key;
    logic [ValueBits-1:0] value;
  } entry_t;

  entry_t lru_list[$];
  int     capacity;
  rsp_t   expected_rsp[$];

  function automatic int find_entry(logic [31:0] x, bit by_value);
    for (int i = 0; i < lru_list.size(); i++)
      if ((by_value ? lru_list[i].value : lru_list[i].key) == x) return i;
    return -1;
  endfunction

  function automatic int make_room();
    int n;
    n = 0;
    while (lru_list.size() >= capacity && lru_list.size() > 0) begin
      void'(lru_list.pop_back());
      n++;
    end
    return n;
  endfunction

  function automatic rsp_t predict_request(req_t r);
    rsp_t   o;
    int     idx;
    entry_t e;
    o = '0;
    e.key = r.key;
    e.value = r.value_in;
    case (r.kind) inside
      KIND_FIND, KIND_GET: begin
        idx = find_entry(r.key, 1'b0);
        if (idx >= 0) begin
          o.hit = 1'b1;
          o.value_out = lru_list[idx].value;
          if (r.move_to_front) begin
            e = lru_list[idx];
            lru_list.delete(idx);
            lru_list.push_front(e);
          end
        end else if (r.kind == KIND_GET) begin
          o.evictions = 5'(make_room());
          lru_list.push_front(e);
          o.hit = 1'b1;
          o.value_out = r.value_in;
        end
      end
      KIND_ADD: begin
        o.evictions = 5'(make_room());
        lru_list.push_front(e);
        o.value_out = r.value_in;
      end
      KIND_DEL_KEY, KIND_DEL_VAL: begin
        idx = find_entry(r.kind == KIND_DEL_KEY ? r.key : r.value_in,
                         r.kind == KIND_DEL_VAL);
        if (idx >= 0) begin
          o.hit = 1'b1;
          o.value_out = lru_list[idx].value;
          lru_list.delete(idx);
        end
      end
      KIND_CLEAR: lru_list.delete();
      default: ;
    endcase
    o.entry_count = 5'(lru_list.size());
    return o;
  endfunction

  assign pending = expected_rsp.size();

  always @(posedge clk) begin
    rsp_t exp_r;
    if (rst) begin
      lru_list.delete();
      expected_rsp.delete();
      capacity <= Depth;
      fail_count <= 0;
    end else begin
      if (cfg_we && cfg_data != 0) capacity <= (cfg_data > Depth) ? Depth : cfg_data;
      if (in_valid && !in_stall) expected_rsp.push_back(predict_request(in_data));
      if (out_valid && !out_stall) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected result item %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_rsp.pop_front();
          if (exp_r !== out_data) begin
            $display({"%0t: mismatch expected hit=%0d value=%h count=%0d ev=%0d,",
                      " got hit=%0d value=%h count=%0d ev=%0d"},
                     $time, exp_r.hit, exp_r.value_out, exp_r.entry_count, exp_r.evictions,
                     out_data.hit, out_data.value_out, out_data.entry_count,
                     out_data.evictions);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### verif/tb_lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache
// Drives directed and random requests through the cache under several
// capacity settings and idle patterns; the checker judges the results.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;
  timeunit 1ns;
  timeprecision 1ps;
  import lkv_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  req_t       in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  rsp_t       out_data;
  logic       cfg_we = 1'b0;
  logic [4:0] cfg_data = '0;
  int         fail_count;
  int         pending;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  logic       hold_req = 1'b0;
  logic       hold_seen = 1'b0;
  int         hold_off = 0;

  always #5 clk = ~clk;

  lru_key_value_cache u_dut (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_data
  );

  lru_cache_checker u_chk (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_data, .fail_count, .pending
  );

  // Receiver: random stall, or a counted long hold-off once requested.
  always @(posedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_off  <= 200;
      out_stall <= 1'b1;
    end else if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Small key/value pool so hits, duplicates and deletes happen often.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'hFFFF_FFFF;
      1: return 32'h0;
      2: return $urandom();
      default: return $urandom_range(11);
    endcase
  endfunction

  // Leave valid high on return; the next request or an idle phase drops it.
  task automatic send_request(logic [2:0] kind, logic [31:0] key, logic [31:0] value,
                              logic mtf);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{kind: kind, key: key, value_in: value, move_to_front: mtf};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random(int n);
    int r;
    logic [2:0] k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      k = r < 25 ? KIND_FIND : r < 45 ? KIND_GET : r < 75 ? KIND_ADD :
          r < 85 ? KIND_DEL_KEY : r < 95 ? KIND_DEL_VAL : r < 98 ? KIND_CLEAR :
          3'($urandom_range(7, 6));
      send_request(k, pick_word(), pick_word(), $urandom_range(1));
    end
  endtask

  // Drain, then write the capacity while idle.
  task automatic set_capacity(logic [4:0] cap);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: extremes, every kind, duplicates, misses, unused kinds.
    send_request(KIND_FIND, 32'h0, 32'h0, 1'b0);
    send_request(KIND_DEL_KEY, 32'h5, 32'h0, 1'b0);
    send_request(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_request(KIND_ADD, 32'h1, 32'hA, 1'b0);
    send_request(KIND_ADD, 32'h1, 32'hB, 1'b0);
    send_request(KIND_GET, 32'h2, 32'hC, 1'b0);
    send_request(KIND_GET, 32'h2, 32'hD, 1'b1);
    send_request(KIND_FIND, 32'hFFFF_FFFF, 32'h0, 1'b1);
    send_request(KIND_FIND, 32'h1, 32'h0, 1'b0);
    send_request(KIND_DEL_VAL, 32'h0, 32'hA, 1'b0);
    send_request(KIND_DEL_VAL, 32'h0, 32'h5555_5555, 1'b0);
    send_request(KIND_DEL_KEY, 32'h1, 32'h0, 1'b0);
    send_request(3'd6, 32'h1, 32'h1, 1'b1);
    send_request(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_request(KIND_CLEAR, 32'h0, 32'h0, 1'b0);
    for (int i = 0; i < 18; i++) send_request(KIND_ADD, i, ~i, 1'b0);
    set_capacity(5'd3);
    send_request(KIND_GET, 32'h77, 32'h1, 1'b0);
    set_capacity(5'd0);
    send_request(KIND_ADD, 32'h78, 32'h2, 1'b0);
    set_capacity(5'd31);
    send_random(150);
    set_capacity(5'd1);
    send_idle_pct = 74;
    send_random(120);
    set_capacity(5'd4);
    send_idle_pct = 0;
    stall_pct = 74;
    send_random(150);
    set_capacity(5'd16);
    send_idle_pct = 25;
    stall_pct = 25;
    send_random(150);
    set_capacity(5'd8);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    send_random(130);
    set_capacity(5'd2);
    send_random(100);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("[lru_key_value_cache] OK");
    else $display("[lru_key_value_cache] ERROR");
    $finish;
  end

  initial begin
    #2ms;
    $display("[lru_key_value_cache] ERROR");
    $finish;
  end
endmodule
